// ===== src/vse_pkg.sv =====
package vse_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int ADDR_W    = $clog2(MAX_DIM);
    localparam int CNT_W     = $clog2(MAX_DIM + 2);
    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = 44;
    localparam int WIDE_W    = 2 * ACC_W;
    localparam int REM_W     = ACC_W + 4;
    localparam int STEP_W    = $clog2(WIDE_W + 1);
    localparam int RES_W     = 42;

    localparam logic signed [ACC_W:0] ACC_MAX = 45'sd8796093022207;
    localparam logic signed [ACC_W:0] ACC_MIN = -45'sd8796093022207;
    localparam logic [WIDE_W-1:0]     RES_LIM = WIDE_W'(64'd1099511627776);

    localparam logic [2:0] MODE_DOT  = 3'd0;
    localparam logic [2:0] MODE_L2   = 3'd1;
    localparam logic [2:0] MODE_COS  = 3'd2;
    localparam logic [2:0] MODE_LOAD = 3'd3;
    localparam logic [2:0] MODE_QCOS = 3'd4;

    localparam logic [1:0] KIND_DOT  = 2'd0;
    localparam logic [1:0] KIND_L2   = 2'd1;
    localparam logic [1:0] KIND_COS  = 2'd2;
    localparam logic [1:0] KIND_QCOS = 2'd3;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

endpackage

// ===== src/vse_arith.sv =====
module vse_arith (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  vse_pkg::arith_ctrl_t       ctrl_i,
    input  logic [vse_pkg::WIDE_W-1:0] wide_i,
    input  logic [vse_pkg::ACC_W-1:0]  narrow_i,
    output vse_pkg::arith_stat_t       stat_o,
    output logic [vse_pkg::WIDE_W-1:0] work_o,
    output logic [vse_pkg::ACC_W-1:0]  root_o
);
    import vse_pkg::*;

    logic [WIDE_W-1:0] work_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  root_reg;
    logic [STEP_W-1:0] cnt_reg;
    arith_op_t         op_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  subtrahend;
    logic [REM_W:0]    diff;
    logic              take;
    logic [ACC_W:0]    mul_sum;

    // one compare-subtract serves both the root and the divide
    always_comb begin
        if (op_reg == OP_SQRT) begin
            rem_sh     = {rem_reg[REM_W-3:0], work_reg[WIDE_W-1 -: 2]};
            subtrahend = {2'b00, root_reg, 2'b01};
        end else begin
            rem_sh     = {rem_reg[REM_W-2:0], work_reg[WIDE_W-1]};
            subtrahend = {4'b0000, root_reg};
        end
        diff    = {1'b0, rem_sh} - {1'b0, subtrahend};
        take    = !diff[REM_W];
        mul_sum = {1'b0, work_reg[WIDE_W-1:ACC_W]}
                + (work_reg[0] ? {1'b0, root_reg} : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end else begin
            done_reg <= !ctrl_i.start && busy_reg && (cnt_reg == STEP_W'(1));
            if (ctrl_i.start) begin
                busy_reg <= 1'b1;
                op_reg   <= ctrl_i.op;
                work_reg <= wide_i;
                rem_reg  <= '0;
                root_reg <= (ctrl_i.op == OP_SQRT) ? '0 : narrow_i;
                cnt_reg  <= (ctrl_i.op == OP_DIV) ? STEP_W'(WIDE_W) : STEP_W'(ACC_W);
            end else if (busy_reg) begin
                case (op_reg)
                    OP_SQRT: begin
                        rem_reg  <= take ? diff[REM_W-1:0] : rem_sh;
                        root_reg <= {root_reg[ACC_W-2:0], take};
                        work_reg <= {work_reg[WIDE_W-3:0], 2'b00};
                    end
                    OP_DIV: begin
                        rem_reg  <= take ? diff[REM_W-1:0] : rem_sh;
                        work_reg <= {work_reg[WIDE_W-2:0], take};
                    end
                    default: begin
                        work_reg <= {mul_sum, work_reg[ACC_W-1:1]};
                    end
                endcase
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat_o.busy = busy_reg;
    assign stat_o.done = done_reg;
    assign work_o      = work_reg;
    assign root_o      = root_reg;

endmodule

// ===== src/vector_similarity_engine_core.sv =====
// Element item: accept, query read, then multiply-accumulate steps (dot, norm a,
//   norm b, squared difference) on one shared 17x17 multiplier; the next transfer is
//   accepted only once this item is done. Closing item: the result follows shift-add
//   multiply (cosine), square root and long division (cosine) on one shared unit.
//   Query load items are written to the store and return to idle.
// Result holds in an output register until the downstream transfer.
// aresetn (synchronous, active low) clears accumulators, counts and query length.
module vector_similarity_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic [2:0]  s_tuser,   // [2:0] mode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [41:0] result_value, [47:42] zero
    output logic [3:0]  m_tuser    // [1:0] result_kind, [2] length_error, [3] saturated
);
    import vse_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_MAC   = 9'b000000100,
        S_FIN   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_ROOT  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_PACK  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t                     state_reg;
    logic [2:0]                 mode_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] b_reg;
    logic                       last_reg;
    logic [1:0]                 step_reg;
    logic                       ok_reg;
    logic signed [ACC_W-1:0]    acc_dot_reg;
    logic signed [ACC_W-1:0]    acc_n1_reg;
    logic signed [ACC_W-1:0]    acc_n2_reg;
    logic signed [ACC_W-1:0]    acc_dsq_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           qlen_reg;
    logic                       flag_reg;
    logic [SAMPLE_W-1:0]        q_rdata_reg;
    logic [WIDE_W-1:0]          mag_reg;
    logic                       neg_reg;
    logic                       m_tvalid_reg;
    logic [RES_W-1:0]           value_reg;
    logic [1:0]                 kind_reg;
    logic                       lerr_reg;
    logic                       sat_reg;
    arith_ctrl_t                actrl_reg;
    logic [WIDE_W-1:0]          awide_reg;
    logic [ACC_W-1:0]           anarrow_reg;

    logic [SAMPLE_W-1:0]        query_mem [MAX_DIM];

    arith_stat_t                astat;
    logic [WIDE_W-1:0]          awork;
    logic [ACC_W-1:0]           aroot;

    logic                       ok;
    logic signed [SAMPLE_W-1:0] a_eff;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W:0]   op_x;
    logic signed [SAMPLE_W:0]   op_y;
    logic signed [2*SAMPLE_W+1:0] prod;
    logic signed [ACC_W-1:0]    acc_sel;
    logic signed [ACC_W:0]      acc_sum;
    logic signed [ACC_W-1:0]    acc_new;
    logic [ACC_W-1:0]           dot_mag;
    logic [WIDE_W-1:0]          mag_cap;
    logic                       start_next;

    vse_arith u_arith (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_i   (actrl_reg),
        .wide_i   (awide_reg),
        .narrow_i (anarrow_reg),
        .stat_o   (astat),
        .work_o   (awork),
        .root_o   (aroot)
    );

    // query store: write on load items, registered read at the current position
    always_ff @(posedge aclk) begin
        if (state_reg == S_FETCH && mode_reg == MODE_LOAD && count_reg < CNT_W'(MAX_DIM)) begin
            query_mem[count_reg[ADDR_W-1:0]] <= a_reg;
        end
        q_rdata_reg <= query_mem[count_reg[ADDR_W-1:0]];
    end

    always_comb begin
        // element lies within range, and within the stored query for the batch form
        ok = (count_reg < CNT_W'(MAX_DIM)) && ((mode_reg != MODE_QCOS) || (count_reg < qlen_reg));
        a_eff = (mode_reg == MODE_QCOS) ? q_rdata_reg : a_reg;
        diff  = {a_eff[SAMPLE_W-1], a_eff} - {b_reg[SAMPLE_W-1], b_reg};
        case (step_reg)
            2'd0: begin
                op_x    = {a_eff[SAMPLE_W-1], a_eff};
                op_y    = {b_reg[SAMPLE_W-1], b_reg};
                acc_sel = acc_dot_reg;
            end
            2'd1: begin
                op_x    = {a_eff[SAMPLE_W-1], a_eff};
                op_y    = {a_eff[SAMPLE_W-1], a_eff};
                acc_sel = acc_n1_reg;
            end
            2'd2: begin
                op_x    = {b_reg[SAMPLE_W-1], b_reg};
                op_y    = {b_reg[SAMPLE_W-1], b_reg};
                acc_sel = acc_n2_reg;
            end
            default: begin
                op_x    = diff;
                op_y    = diff;
                acc_sel = acc_dsq_reg;
            end
        endcase
        prod    = op_x * op_y;
        acc_sum = {acc_sel[ACC_W-1], acc_sel} + (ACC_W + 1)'(prod);
        // clamp silently at plus or minus the accumulator limit
        if (acc_sum > ACC_MAX) begin
            acc_new = ACC_MAX[ACC_W-1:0];
        end else if (acc_sum < ACC_MIN) begin
            acc_new = ACC_MIN[ACC_W-1:0];
        end else begin
            acc_new = acc_sum[ACC_W-1:0];
        end
        dot_mag = acc_dot_reg[ACC_W-1] ? ACC_W'(-acc_dot_reg) : ACC_W'(acc_dot_reg);
        mag_cap = (mag_reg > RES_LIM) ? RES_LIM : mag_reg;
    end

    // pulse the shared unit's start whenever a new operation is handed to it
    always_comb begin
        case (state_reg)
            S_FIN:   start_next = (mode_reg != MODE_DOT);
            S_MUL:   start_next = astat.done;
            S_ROOT:  start_next = astat.done && (mode_reg != MODE_L2) && (aroot != '0);
            default: start_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            acc_dot_reg  <= '0;
            acc_n1_reg   <= '0;
            acc_n2_reg   <= '0;
            acc_dsq_reg  <= '0;
            count_reg    <= '0;
            qlen_reg     <= '0;
            flag_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            actrl_reg    <= '{start: 1'b0, op: OP_MUL};
        end else begin
            actrl_reg.start <= start_next;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg  <= s_tuser;
                        a_reg     <= s_tdata[15:0];
                        b_reg     <= s_tdata[31:16];
                        last_reg  <= s_tlast;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    step_reg <= 2'd0;
                    ok_reg   <= ok;
                    if (mode_reg > MODE_QCOS) begin
                        state_reg <= S_IDLE;
                    end else if (mode_reg == MODE_LOAD) begin
                        // query load: on last, fix the length and start a fresh vector
                        if (last_reg) begin
                            qlen_reg    <= (count_reg >= CNT_W'(MAX_DIM))
                                         ? CNT_W'(MAX_DIM) : count_reg + 1'b1;
                            acc_dot_reg <= '0;
                            acc_n1_reg  <= '0;
                            acc_n2_reg  <= '0;
                            acc_dsq_reg <= '0;
                            count_reg   <= '0;
                            flag_reg    <= 1'b0;
                        end else if (count_reg <= CNT_W'(MAX_DIM)) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (ok_reg) begin
                        case (step_reg)
                            2'd0:    acc_dot_reg <= acc_new;
                            2'd1:    acc_n1_reg  <= acc_new;
                            2'd2:    acc_n2_reg  <= acc_new;
                            default: acc_dsq_reg <= acc_new;
                        endcase
                    end
                    step_reg <= step_reg + 1'b1;
                    if (!ok_reg || step_reg == 2'd3) begin
                        if (!ok_reg) begin
                            flag_reg <= 1'b1;
                        end
                        if (count_reg <= CNT_W'(MAX_DIM)) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= last_reg ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    case (mode_reg)
                        MODE_DOT: begin
                            mag_reg   <= WIDE_W'(dot_mag);
                            neg_reg   <= acc_dot_reg[ACC_W-1];
                            state_reg <= S_PACK;
                        end
                        MODE_L2: begin
                            // radicand: squared-difference sum scaled by 2^30
                            awide_reg    <= {(WIDE_W - ACC_W - 29)'(0), acc_dsq_reg[ACC_W-2:0],
                                             30'd0};
                            actrl_reg.op <= OP_SQRT;
                            state_reg    <= S_ROOT;
                        end
                        default: begin
                            awide_reg    <= WIDE_W'(acc_n1_reg);
                            anarrow_reg  <= acc_n2_reg;
                            actrl_reg.op <= OP_MUL;
                            state_reg    <= S_MUL;
                        end
                    endcase
                end
                S_MUL: begin
                    if (astat.done) begin
                        awide_reg    <= awork;
                        actrl_reg.op <= OP_SQRT;
                        state_reg    <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (astat.done) begin
                        if (mode_reg == MODE_L2 || aroot == '0) begin
                            // L2 takes the root as its result; a zero norm product gives a zero cosine
                            mag_reg   <= (mode_reg == MODE_L2) ? WIDE_W'(aroot) : '0;
                            neg_reg   <= 1'b0;
                            state_reg <= S_PACK;
                        end else begin
                            awide_reg    <= {(WIDE_W - ACC_W - 30)'(0), dot_mag, 30'd0};
                            anarrow_reg  <= aroot;
                            actrl_reg.op <= OP_DIV;
                            state_reg    <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (astat.done) begin
                        mag_reg   <= awork;
                        neg_reg   <= acc_dot_reg[ACC_W-1];
                        state_reg <= S_PACK;
                    end
                end
                S_PACK: begin
                    value_reg <= neg_reg ? RES_W'(-mag_cap) : RES_W'(mag_cap);
                    sat_reg   <= (mag_reg > RES_LIM);
                    lerr_reg  <= flag_reg;
                    case (mode_reg)
                        MODE_DOT: kind_reg <= KIND_DOT;
                        MODE_L2:  kind_reg <= KIND_L2;
                        MODE_COS: kind_reg <= KIND_COS;
                        default:  kind_reg <= KIND_QCOS;
                    endcase
                    // drop the vector state once its result is formed
                    acc_dot_reg  <= '0;
                    acc_n1_reg   <= '0;
                    acc_n2_reg   <= '0;
                    acc_dsq_reg  <= '0;
                    count_reg    <= '0;
                    flag_reg     <= 1'b0;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    // hold the result until the downstream transfer
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, value_reg};
    assign m_tuser  = {sat_reg, lerr_reg, kind_reg};

    a_out_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> state_reg == S_OUT)
        else $error("result shown outside output state");

    a_unit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        astat.busy |-> (state_reg == S_MUL || state_reg == S_ROOT || state_reg == S_DIV))
        else $error("shared unit running outside its states");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_DIM + 1))
        else $error("element count past its cap");

    a_qlen_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        qlen_reg <= CNT_W'(MAX_DIM))
        else $error("query length beyond store depth");

    a_accept_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == S_FETCH)
        else $error("accepted item not fetched");

endmodule
